// File: hdl/iee_pkg.sv
// ---------------------------------------------------------------------------
// iee_pkg
// Shared types and constants of the infix expression evaluator.
// ---------------------------------------------------------------------------
package iee_pkg;

    localparam int OPERATOR_DEPTH_DEF = 16;
    localparam int VALUE_DEPTH_DEF    = 16;
    localparam int DATA_WIDTH_DEF     = 32;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_PAREN = 3'd1,
        OP_ADD   = 3'd2,
        OP_SUB   = 3'd3,
        OP_MUL   = 3'd4,
        OP_DIV   = 3'd5,
        OP_RPAR  = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_DIV0 = 2'd2,
        ST_OVF  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ALU_IDLE = 3'd0,
        ALU_MUL  = 3'd1,
        ALU_DIV  = 3'd2,
        ALU_DONE = 3'd3
    } alu_state_t;

    typedef enum logic [3:0] {
        S_IDLE    = 4'd0,
        S_PUSHZ   = 4'd1,
        S_PEEK    = 4'd2,
        S_POPA    = 4'd3,
        S_POPB    = 4'd4,
        S_CALC    = 4'd5,
        S_WAIT    = 4'd6,
        S_PUSHOP  = 4'd7,
        S_FINAL   = 4'd8,
        S_RESULT  = 4'd9,
        S_RESULT2 = 4'd10,
        S_OUT     = 4'd11,
        S_NUM     = 4'd12
    } state_t;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        MODE_OP   = 2'd0,
        MODE_RPAR = 2'd1,
        MODE_END  = 2'd2
    } mode_t;

    function automatic logic [1:0] rank(input logic [2:0] code);
        logic [1:0] r;
        r = 2'd0;
        if (code == OP_MUL || code == OP_DIV) r = 2'd2;
        else if (code == OP_ADD || code == OP_SUB) r = 2'd1;
        return r;
    endfunction

endpackage

// File: hdl/infix_expression_evaluator.sv
// ---------------------------------------------------------------------------
// infix_expression_evaluator
// Streaming shunting-yard evaluator of + - * / and parentheses.
// ---------------------------------------------------------------------------
// Usage: feed one character per item on char_code with last_char marking the
// final character. The block evaluates in place with an operator stack and a
// value stack held in small memories. On the last character it delivers one
// item on value/status; other characters give no result.
// Rate: one item at a time; in_ready stays low while an item is in work. A
// closing parenthesis or an operator pops stacked operators (a unary minus
// first pushes a zero value); each popped operator takes its two values off
// the value stack and goes through the shared ALU: add or subtract directly,
// multiply or divide bit-serially. The end of an expression pops all
// remaining operators the same way.
// Reset clears the stack counts, the flags (but sets expect) and out_valid;
// stack contents need no clearing, since entries are read only below their counts.
// A stalled receiver holds the result; in_ready stays low until it is taken.
// After the result the block returns to its reset state for the next
// expression.
// ---------------------------------------------------------------------------
module infix_expression_evaluator
    import iee_pkg::*;
#(
    parameter int OPERATOR_DEPTH = OPERATOR_DEPTH_DEF,
    parameter int VALUE_DEPTH    = VALUE_DEPTH_DEF,
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] value,
    output logic [1:0]  status
);

    localparam int OAW = (OPERATOR_DEPTH > 1) ? $clog2(OPERATOR_DEPTH) : 1;
    localparam int VAW = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;
    localparam int OCW = $clog2(OPERATOR_DEPTH + 1);
    localparam int VCW = $clog2(VALUE_DEPTH + 1);

    // stacks
    logic [2:0]            op_mem [OPERATOR_DEPTH];
    logic [DATA_WIDTH-1:0] val_mem [VALUE_DEPTH];
    logic [2:0]            op_rd_reg;
    logic [DATA_WIDTH-1:0] val_rd_reg;

    state_t                state_reg, state_next;
    mode_t                 mode_reg, mode_next;
    logic [OCW-1:0]        ocnt_reg, ocnt_next;
    logic [VCW-1:0]        vcnt_reg, vcnt_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic                  innum_reg, innum_next;
    logic                  expect_reg, expect_next;
    logic [1:0]            err_reg, err_next;
    logic [2:0]            code_reg, code_next;
    logic [2:0]            popop_reg, popop_next;
    logic                  last_reg, last_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic                  ovalid_reg, ovalid_next;
    logic [31:0]           oval_reg, oval_next;
    logic [1:0]            ostat_reg, ostat_next;

    // memory port controls
    logic                  op_we, val_we;
    logic [OAW-1:0]        op_wa, op_ra;
    logic [VAW-1:0]        val_wa, val_ra;
    logic [2:0]            op_wd;
    logic [DATA_WIDTH-1:0] val_wd;

    logic                  alu_start, alu_done;
    logic [DATA_WIDTH-1:0] alu_result;
    logic [2:0]            ch_code;
    logic                  is_digit;
    logic [DATA_WIDTH-1:0] acc_mul10;

    iee_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .op     (popop_reg),
        .a      (a_reg),
        .b      (b_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    always_ff @(posedge clk)
    begin
        if (op_we) op_mem[op_wa] <= op_wd;
        if (val_we) val_mem[val_wa] <= val_wd;
        op_rd_reg  <= op_mem[op_ra];
        val_rd_reg <= val_mem[val_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ocnt_reg   <= '0;
            vcnt_reg   <= '0;
            acc_reg    <= '0;
            innum_reg  <= 1'b0;
            expect_reg <= 1'b1;
            err_reg    <= ST_OK;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ocnt_reg   <= ocnt_next;
            vcnt_reg   <= vcnt_next;
            acc_reg    <= acc_next;
            innum_reg  <= innum_next;
            expect_reg <= expect_next;
            err_reg    <= err_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        code_reg  <= code_next;
        popop_reg <= popop_next;
        last_reg  <= last_next;
        b_reg     <= b_next;
        a_reg     <= a_next;
        oval_reg  <= oval_next;
        ostat_reg <= ostat_next;
    end

    assign is_digit  = (char_code >= CH_0) && (char_code <= CH_9);
    assign acc_mul10 = (acc_reg << 3) + (acc_reg << 1);

    always_comb
    begin
        case (char_code)
            CH_LPAR:  ch_code = OP_PAREN;
            CH_RPAR:  ch_code = OP_RPAR;
            CH_PLUS:  ch_code = OP_ADD;
            CH_MINUS: ch_code = OP_SUB;
            CH_STAR:  ch_code = OP_MUL;
            CH_SLASH: ch_code = OP_DIV;
            default:  ch_code = OP_NONE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE) && !ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        ocnt_next   = ocnt_reg;
        vcnt_next   = vcnt_reg;
        acc_next    = acc_reg;
        innum_next  = innum_reg;
        expect_next = expect_reg;
        err_next    = err_reg;
        code_next   = code_reg;
        popop_next  = popop_reg;
        last_next   = last_reg;
        b_next      = b_reg;
        a_next      = a_reg;
        ovalid_next = ovalid_reg;
        oval_next   = oval_reg;
        ostat_next  = ostat_reg;
        op_we       = 1'b0;
        val_we      = 1'b0;
        op_wa       = ocnt_reg[OAW-1:0];
        op_wd       = code_reg;
        val_wa      = vcnt_reg[VAW-1:0];
        val_wd      = acc_reg;
        op_ra       = OAW'(ocnt_reg - 1'b1);
        val_ra      = VAW'(vcnt_reg - 1'b1);
        alu_start   = 1'b0;

        if (ovalid_reg && out_ready) ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    last_next = last_char;
                    code_next = ch_code;
                    if (err_reg != ST_OK)
                    begin
                        state_next = last_char ? S_RESULT : S_IDLE;
                    end
                    else if (is_digit)
                    begin
                        acc_next    = acc_mul10 + DATA_WIDTH'(char_code - CH_0);
                        innum_next  = 1'b1;
                        expect_next = 1'b0;
                        state_next  = last_char ? S_FINAL : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_NUM;
                    end
                end
            end
            S_NUM:
            begin
                // close a pending number, then dispatch the character
                if (innum_reg)
                begin
                    innum_next = 1'b0;
                    acc_next   = '0;
                    if (vcnt_reg >= VCW'(VALUE_DEPTH))
                    begin
                        err_next = ST_OVF;
                    end
                    else
                    begin
                        val_we    = 1'b1;
                        vcnt_next = vcnt_reg + 1'b1;
                    end
                end
                if (innum_reg && vcnt_reg >= VCW'(VALUE_DEPTH))
                begin
                    state_next = last_reg ? S_RESULT : S_IDLE;
                end
                else if (code_reg == OP_PAREN)
                begin
                    if (ocnt_reg >= OCW'(OPERATOR_DEPTH))
                    begin
                        err_next = ST_OVF;
                    end
                    else
                    begin
                        op_we     = 1'b1;
                        ocnt_next = ocnt_reg + 1'b1;
                    end
                    expect_next = 1'b1;
                    state_next  = last_reg ? S_FINAL : S_IDLE;
                end
                else if (code_reg == OP_RPAR)
                begin
                    mode_next  = MODE_RPAR;
                    state_next = S_PEEK;
                end
                else if (code_reg == OP_NONE)
                begin
                    state_next = last_reg ? S_FINAL : S_IDLE;
                end
                else
                begin
                    mode_next  = MODE_OP;
                    state_next = (code_reg == OP_SUB && expect_reg) ? S_PUSHZ : S_PEEK;
                end
            end
            S_PUSHZ:
            begin
                if (vcnt_reg >= VCW'(VALUE_DEPTH))
                begin
                    err_next   = ST_OVF;
                    state_next = last_reg ? S_RESULT : S_IDLE;
                end
                else
                begin
                    val_we     = 1'b1;
                    val_wd     = '0;
                    vcnt_next  = vcnt_reg + 1'b1;
                    state_next = S_PEEK;
                end
            end
            S_PEEK:
            begin
                // read top operator; decision made in S_POPA
                if (ocnt_reg == '0)
                begin
                    unique case (mode_reg)
                        MODE_OP:   state_next = S_PUSHOP;
                        MODE_RPAR:
                        begin
                            expect_next = 1'b0;
                            state_next  = last_reg ? S_FINAL : S_IDLE;
                        end
                        default:   state_next = S_RESULT;
                    endcase
                end
                else
                begin
                    state_next = S_POPA;
                end
            end
            S_POPA:
            begin
                popop_next = op_rd_reg;
                if (mode_reg == MODE_OP && rank(op_rd_reg) < rank(code_reg))
                begin
                    state_next = S_PUSHOP;
                end
                else if (mode_reg == MODE_RPAR && op_rd_reg == OP_PAREN)
                begin
                    ocnt_next   = ocnt_reg - 1'b1;
                    expect_next = 1'b0;
                    state_next  = last_reg ? S_FINAL : S_IDLE;
                end
                else if (mode_reg == MODE_END && op_rd_reg == OP_PAREN)
                begin
                    ocnt_next  = ocnt_reg - 1'b1;
                    state_next = S_PEEK;
                end
                else
                begin
                    ocnt_next = ocnt_reg - 1'b1;
                    if (vcnt_reg < VCW'(2))
                    begin
                        err_next   = ST_FEW;
                        state_next = (mode_reg == MODE_END || last_reg) ? S_RESULT : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_POPB;
                    end
                end
            end
            S_POPB:
            begin
                // val_rd_reg holds b; now fetch a
                b_next     = val_rd_reg;
                val_ra     = VAW'(vcnt_reg - 2'd2);
                state_next = S_CALC;
            end
            S_CALC:
            begin
                a_next = val_rd_reg;
                if (popop_reg == OP_DIV && b_reg == '0)
                begin
                    err_next   = ST_DIV0;
                    state_next = (mode_reg == MODE_END || last_reg) ? S_RESULT : S_IDLE;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                alu_start = (popop_reg != OP_NONE) && !alu_done;
                if (alu_done)
                begin
                    alu_start  = 1'b0;
                    val_we     = 1'b1;
                    val_wa     = VAW'(vcnt_reg - 2'd2);
                    val_wd     = alu_result;
                    vcnt_next  = vcnt_reg - 1'b1;
                    popop_next = OP_NONE;
                    state_next = S_PEEK;
                end
            end
            S_PUSHOP:
            begin
                if (ocnt_reg >= OCW'(OPERATOR_DEPTH))
                begin
                    err_next = ST_OVF;
                end
                else
                begin
                    op_we     = 1'b1;
                    ocnt_next = ocnt_reg + 1'b1;
                end
                expect_next = 1'b1;
                state_next  = last_reg ? S_FINAL : S_IDLE;
            end
            S_FINAL:
            begin
                // end of expression: flush number, then pop everything
                if (err_reg != ST_OK)
                begin
                    state_next = S_RESULT;
                end
                else if (innum_reg)
                begin
                    innum_next = 1'b0;
                    acc_next   = '0;
                    if (vcnt_reg >= VCW'(VALUE_DEPTH))
                    begin
                        err_next   = ST_OVF;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        val_we    = 1'b1;
                        vcnt_next = vcnt_reg + 1'b1;
                    end
                end
                else
                begin
                    mode_next  = MODE_END;
                    state_next = S_PEEK;
                end
            end
            S_RESULT:
            begin
                state_next = S_RESULT2;
            end
            S_RESULT2:
            begin
                // top value read registered during S_RESULT
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                    if (err_reg == ST_OK && vcnt_reg == '0)
                    begin
                        ostat_next = ST_FEW;
                        oval_next  = '0;
                    end
                    else if (err_reg == ST_OK)
                    begin
                        ostat_next = ST_OK;
                        oval_next  = 32'(val_rd_reg);
                    end
                    else
                    begin
                        ostat_next = err_reg;
                        oval_next  = '0;
                    end
                    ocnt_next   = '0;
                    vcnt_next   = '0;
                    acc_next    = '0;
                    innum_next  = 1'b0;
                    expect_next = 1'b1;
                    err_next    = ST_OK;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = ovalid_reg;
    assign value     = oval_reg;
    assign status    = ostat_reg;

endmodule

// File: hdl/iee_alu.sv
// ---------------------------------------------------------------------------
// iee_alu
// Shared arithmetic unit: add and subtract directly, multiply by
// shift-and-add and divide by restoring shift-subtract, one bit a cycle.
// ---------------------------------------------------------------------------
module iee_alu
    import iee_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2:0]            op,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    alu_state_t            state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] opa_reg, opa_next;
    logic [DATA_WIDTH-1:0] opb_reg, opb_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic                  neg_reg, neg_next;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH-1:0] ma, mb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ALU_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign ma = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
    assign mb = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
    assign trial = {rem_reg, opa_reg[DATA_WIDTH-1]} - {1'b0, opb_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            ALU_IDLE:
            begin
                if (start)
                begin
                    cnt_next = CW'(DATA_WIDTH);
                    rem_next = '0;
                    acc_next = '0;
                    case (op)
                        OP_ADD:
                        begin
                            acc_next   = a + b;
                            state_next = ALU_DONE;
                        end
                        OP_SUB:
                        begin
                            acc_next   = a - b;
                            state_next = ALU_DONE;
                        end
                        OP_MUL:
                        begin
                            opa_next   = a;
                            opb_next   = b;
                            state_next = ALU_MUL;
                        end
                        default:
                        begin
                            opa_next   = ma;
                            opb_next   = mb;
                            neg_next   = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
                            state_next = ALU_DIV;
                        end
                    endcase
                end
            end
            ALU_MUL:
            begin
                // add shifted multiplicand where the multiplier bit is set
                if (opb_reg[0]) acc_next = acc_reg + opa_reg;
                opa_next = opa_reg << 1;
                opb_next = opb_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) state_next = ALU_DONE;
            end
            ALU_DIV:
            begin
                if (!trial[DATA_WIDTH])
                begin
                    rem_next = trial[DATA_WIDTH-1:0];
                    acc_next = {acc_reg[DATA_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[DATA_WIDTH-2:0], opa_reg[DATA_WIDTH-1]};
                    acc_next = {acc_reg[DATA_WIDTH-2:0], 1'b0};
                end
                opa_next = opa_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = ALU_DONE;
                    if (neg_reg)
                    begin
                        acc_next = ~acc_next + 1'b1;
                    end
                end
            end
            ALU_DONE:
            begin
                state_next = ALU_IDLE;
            end
            default:
            begin
                state_next = ALU_IDLE;
            end
        endcase
    end

    assign done   = (state_reg == ALU_DONE);
    assign result = acc_reg;

endmodule

// File: hdl/iee_checker.sv
// ---------------------------------------------------------------------------
// iee_checker
// Port-level assertions for the infix expression evaluator.
// ---------------------------------------------------------------------------
module iee_checker
    import iee_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] value,
    input logic [1:0]  status
);

    // an error result always carries value zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (value == '0))
        else $error("error result with nonzero value");

    // a result waiting blocks new input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    // one result per expression: a taken result is not repeated
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> !out_valid)
        else $error("result repeated after accept");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(value) && $stable(status)))
        else $error("result changed under stall");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
);
